// ===== rtl/bgi_pkg.sv =====
package bgi_pkg;

	// item field widths
	localparam int ENTRY_INDEX_W = 13;
	localparam int VALUE_W       = 24;
	localparam int ANGLE_W       = 21;

	// configuration register widths
	localparam int THETA_COUNT_W = 7;
	localparam int PHI_COUNT_W   = 8;
	localparam int ORIGIN_W      = 21;
	localparam int RECIP_W       = 24;
	localparam int CFG_DATA_W    = 24;
	localparam int CFG_INDEX_W   = 3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_THETA_COUNT  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PHI_COUNT    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_THETA_ORIGIN = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PHI_ORIGIN   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_THETA_RECIP  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_PHI_RECIP    = 3'd5;

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// angle constants in Q16 radians
	localparam int HALF_PI_Q16 = 102944;
	localparam int TWO_PI_Q16  = 411775;

	// wrapped phi lies in 0..2pi, angle differences need two guard bits
	localparam int PHI_W  = 19;
	localparam int DIFF_W = ANGLE_W + 2;

	// grid position is Q32
	localparam int POS_FRAC = 32;
	localparam int POS_W    = DIFF_W + RECIP_W + 1;

endpackage

// ===== rtl/bgi_req_if.sv =====
interface bgi_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 cmd;
	logic [bgi_pkg::ENTRY_INDEX_W-1:0]    entry_index;
	logic [bgi_pkg::VALUE_W-1:0]          entry_value;
	logic signed [bgi_pkg::ANGLE_W-1:0]   azimuth;
	logic signed [bgi_pkg::ANGLE_W-1:0]   elevation;

	modport source (
		output valid, cmd, entry_index, entry_value, azimuth, elevation,
		input  ready
	);
	modport sink (
		input  valid, cmd, entry_index, entry_value, azimuth, elevation,
		output ready
	);
endinterface

// ===== rtl/bgi_rsp_if.sv =====
interface bgi_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bgi_pkg::VALUE_W-1:0]   area_value;

	modport source (
		output valid, area_value,
		input  ready
	);
	modport sink (
		input  valid, area_value,
		output ready
	);
endinterface

// ===== rtl/bgi_ram.sv =====
module bgi_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/bilinear_grid_interpolator_unit.sv =====
// Bilinear interpolator over a theta/phi grid of 24-bit samples. A write item
// (cmd 0) stores one sample and gives no result; a query item (cmd 1) gives one
// interpolated value. One item is accepted every clock cycle while the result
// side does not stall. The rate is set by the grid store: four copies of the
// grid RAM, each written with every sample, deliver the four corner samples in
// the same read. Writes and reads take place in the same pipeline stage, so
// items act on the grid in the order they were accepted. A stall at the result
// side holds the whole pipeline and drops ready. Configuration must be written
// only while no item is in flight; the block does not enforce this. The grid
// holds no defined value until an entry is written.
module bilinear_grid_interpolator_unit #(
	parameter int THETA_POINTS_MAX = 64,
	parameter int PHI_POINTS_MAX   = 128,
	parameter int FRAC_BITS        = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [bgi_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bgi_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
	bgi_req_if.sink                             request,
	bgi_rsp_if.source                           result
);

	localparam int GRID_DEPTH = THETA_POINTS_MAX * PHI_POINTS_MAX;
	localparam int ADDR_W     = $clog2(GRID_DEPTH);
	localparam int TIDX_W     = $clog2(THETA_POINTS_MAX);
	localparam int PIDX_W     = $clog2(PHI_POINTS_MAX);
	localparam int TCNT_W     = $clog2(THETA_POINTS_MAX + 1);
	localparam int PCNT_W     = $clog2(PHI_POINTS_MAX + 1);
	localparam int F_W        = FRAC_BITS + 1;
	localparam int VW         = bgi_pkg::VALUE_W;
	localparam int PROD_W     = F_W + VW;
	localparam int DW         = bgi_pkg::DIFF_W;
	localparam int PW         = bgi_pkg::POS_W;
	localparam int IW         = bgi_pkg::POS_W - bgi_pkg::POS_FRAC;

	localparam logic [F_W-1:0]       ONE     = F_W'(1) << FRAC_BITS;
	localparam logic [PROD_W:0]      HALF    = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [DW-1:0] HALF_PI = DW'(bgi_pkg::HALF_PI_Q16);
	localparam logic signed [DW-1:0] TWO_PI  = DW'(bgi_pkg::TWO_PI_Q16);

	// configuration registers
	logic [bgi_pkg::THETA_COUNT_W-1:0]  theta_count_q;
	logic [bgi_pkg::PHI_COUNT_W-1:0]    phi_count_q;
	logic signed [bgi_pkg::ORIGIN_W-1:0] theta_origin_q;
	logic signed [bgi_pkg::ORIGIN_W-1:0] phi_origin_q;
	logic [bgi_pkg::RECIP_W-1:0]        theta_recip_q;
	logic [bgi_pkg::RECIP_W-1:0]        phi_recip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_count_q  <= bgi_pkg::THETA_COUNT_W'(2);
			phi_count_q    <= bgi_pkg::PHI_COUNT_W'(2);
			theta_origin_q <= '0;
			phi_origin_q   <= '0;
			theta_recip_q  <= bgi_pkg::RECIP_W'(65536);
			phi_recip_q    <= bgi_pkg::RECIP_W'(65536);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bgi_pkg::CFG_THETA_COUNT: begin
					theta_count_q <= cfg_wr_data[bgi_pkg::THETA_COUNT_W-1:0];
				end
				bgi_pkg::CFG_PHI_COUNT: begin
					phi_count_q <= cfg_wr_data[bgi_pkg::PHI_COUNT_W-1:0];
				end
				bgi_pkg::CFG_THETA_ORIGIN: begin
					theta_origin_q <= $signed(cfg_wr_data[bgi_pkg::ORIGIN_W-1:0]);
				end
				bgi_pkg::CFG_PHI_ORIGIN: begin
					phi_origin_q <= $signed(cfg_wr_data[bgi_pkg::ORIGIN_W-1:0]);
				end
				bgi_pkg::CFG_THETA_RECIP: begin
					theta_recip_q <= cfg_wr_data[bgi_pkg::RECIP_W-1:0];
				end
				bgi_pkg::CFG_PHI_RECIP: begin
					phi_recip_q <= cfg_wr_data[bgi_pkg::RECIP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// effective grid sizes
	logic [TCNT_W-1:0] nt;
	logic [PCNT_W-1:0] np;

	always_comb begin
		if (theta_count_q < bgi_pkg::THETA_COUNT_W'(2)) begin
			nt = TCNT_W'(2);
		end else if (32'(theta_count_q) > 32'(THETA_POINTS_MAX)) begin
			nt = TCNT_W'(THETA_POINTS_MAX);
		end else begin
			nt = TCNT_W'(theta_count_q);
		end
		if (phi_count_q < bgi_pkg::PHI_COUNT_W'(2)) begin
			np = PCNT_W'(2);
		end else if (32'(phi_count_q) > 32'(PHI_POINTS_MAX)) begin
			np = PCNT_W'(PHI_POINTS_MAX);
		end else begin
			np = PCNT_W'(phi_count_q);
		end
	end

	// pipeline advances unless a result waits
	logic adv;
	logic out_valid_q;
	logic [VW-1:0] area_q;

	assign adv           = !out_valid_q || result.ready;
	assign request.ready = adv;
	assign result.valid  = out_valid_q;
	assign result.area_value = area_q;

	logic accept;
	assign accept = request.valid && adv;

	// stage valid and query flags
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic q_s1, q_s2, q_s3, q_s4, q_s5, q_s6, q_s7, q_s8, q_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			v_s8 <= v_s7; v_s9 <= v_s8;
			out_valid_q <= v_s9 && q_s9;
		end
	end

	// stage 1: angle prep and phi wrap
	logic signed [DW-1:0] theta_c, phi_raw, phi_wrap;

	always_comb begin
		theta_c = HALF_PI - DW'(request.elevation);
		phi_raw = HALF_PI - DW'(request.azimuth);
		if (phi_raw > (TWO_PI <<< 1)) begin
			phi_wrap = phi_raw - (TWO_PI <<< 1);
		end else if (phi_raw > TWO_PI) begin
			phi_wrap = phi_raw - TWO_PI;
		end else if (phi_raw >= DW'(0)) begin
			phi_wrap = phi_raw;
		end else if (phi_raw >= -TWO_PI) begin
			phi_wrap = phi_raw + TWO_PI;
		end else if (phi_raw >= -(TWO_PI <<< 1)) begin
			phi_wrap = phi_raw + (TWO_PI <<< 1);
		end else begin
			phi_wrap = phi_raw + TWO_PI + (TWO_PI <<< 1);
		end
	end

	logic signed [DW-1:0]              theta_s1;
	logic [bgi_pkg::PHI_W-1:0]         phi_s1;
	logic signed [DW-1:0]              dt_s2, dp_s2;
	logic signed [PW-1:0]              pt_s3, pp_s3;
	logic [TIDX_W-1:0]                 it_s4;
	logic [PIDX_W-1:0]                 ip_s4;
	logic [F_W-1:0]                    ft_s4, fp_s4, ft_s5, fp_s5, ft_s6, fp_s6;
	logic [F_W-1:0]                    fp_s7, fp_s8;
	logic [ADDR_W-1:0]                 r0_s5;
	logic [bgi_pkg::ENTRY_INDEX_W-1:0] widx_s1, widx_s2, widx_s3, widx_s4, widx_s5;
	logic [VW-1:0]                     wval_s1, wval_s2, wval_s3, wval_s4, wval_s5;
	logic [PROD_W-1:0]                 m00_s7, m01_s7, m10_s7, m11_s7;
	logic [VW-1:0]                     a0_s8, a1_s8;
	logic [PROD_W-1:0]                 n0_s9, n1_s9;

	// stage 4: cell index and fraction
	logic [IW-1:0]     ti, pi_int;
	logic [TIDX_W-1:0] it_c;
	logic [PIDX_W-1:0] ip_c;
	logic [F_W-1:0]    ft_c, fp_c;

	assign ti     = pt_s3[PW-1:bgi_pkg::POS_FRAC];
	assign pi_int = pp_s3[PW-1:bgi_pkg::POS_FRAC];

	always_comb begin
		if (pt_s3[PW-1]) begin
			it_c = '0;
			ft_c = '0;
		end else if (32'(ti) >= 32'(nt) - 32'd1) begin
			it_c = TIDX_W'(nt - TCNT_W'(2));
			ft_c = ONE;
		end else begin
			it_c = TIDX_W'(ti);
			ft_c = {1'b0, pt_s3[bgi_pkg::POS_FRAC-1 -: FRAC_BITS]};
		end
		if (pp_s3[PW-1]) begin
			ip_c = '0;
			fp_c = '0;
		end else if (32'(pi_int) >= 32'(np) - 32'd1) begin
			ip_c = PIDX_W'(np - PCNT_W'(2));
			fp_c = ONE;
		end else begin
			ip_c = PIDX_W'(pi_int);
			fp_c = {1'b0, pp_s3[bgi_pkg::POS_FRAC-1 -: FRAC_BITS]};
		end
	end

	// grid store: four copies, one corner each
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ra00, ra01, ra10, ra11;
	logic [VW-1:0]     g00, g01, g10, g11;

	assign ram_we = adv && v_s5 && !q_s5 && (32'(widx_s5) < 32'(GRID_DEPTH));
	assign ram_waddr = ADDR_W'(widx_s5);
	assign ra00 = r0_s5;
	assign ra01 = r0_s5 + ADDR_W'(1);
	assign ra10 = r0_s5 + ADDR_W'(nt);
	assign ra11 = r0_s5 + ADDR_W'(nt) + ADDR_W'(1);

	bgi_ram #(.WIDTH(VW), .DEPTH(GRID_DEPTH)) u_ram00 (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wval_s5),
		.re(adv), .raddr(ra00), .rdata(g00)
	);
	bgi_ram #(.WIDTH(VW), .DEPTH(GRID_DEPTH)) u_ram01 (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wval_s5),
		.re(adv), .raddr(ra01), .rdata(g01)
	);
	bgi_ram #(.WIDTH(VW), .DEPTH(GRID_DEPTH)) u_ram10 (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wval_s5),
		.re(adv), .raddr(ra10), .rdata(g10)
	);
	bgi_ram #(.WIDTH(VW), .DEPTH(GRID_DEPTH)) u_ram11 (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wval_s5),
		.re(adv), .raddr(ra11), .rdata(g11)
	);

	// blend sums
	logic [PROD_W:0] sum0, sum1, sum_out;
	assign sum0    = (PROD_W + 1)'(m00_s7) + (PROD_W + 1)'(m01_s7) + HALF;
	assign sum1    = (PROD_W + 1)'(m10_s7) + (PROD_W + 1)'(m11_s7) + HALF;
	assign sum_out = (PROD_W + 1)'(n0_s9) + (PROD_W + 1)'(n1_s9) + HALF;

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1 <= request.cmd == bgi_pkg::CMD_QUERY;
			q_s2 <= q_s1; q_s3 <= q_s2; q_s4 <= q_s3; q_s5 <= q_s4;
			q_s6 <= q_s5; q_s7 <= q_s6; q_s8 <= q_s7; q_s9 <= q_s8;

			theta_s1 <= theta_c;
			phi_s1   <= bgi_pkg::PHI_W'(phi_wrap);
			widx_s1  <= request.entry_index;
			wval_s1  <= request.entry_value;

			dt_s2   <= theta_s1 - DW'(theta_origin_q);
			dp_s2   <= DW'(phi_s1) - DW'(phi_origin_q);
			widx_s2 <= widx_s1;
			wval_s2 <= wval_s1;

			pt_s3   <= dt_s2 * $signed({1'b0, theta_recip_q});
			pp_s3   <= dp_s2 * $signed({1'b0, phi_recip_q});
			widx_s3 <= widx_s2;
			wval_s3 <= wval_s2;

			it_s4   <= it_c;
			ft_s4   <= ft_c;
			ip_s4   <= ip_c;
			fp_s4   <= fp_c;
			widx_s4 <= widx_s3;
			wval_s4 <= wval_s3;

			r0_s5   <= ADDR_W'(ip_s4) * ADDR_W'(nt) + ADDR_W'(it_s4);
			ft_s5   <= ft_s4;
			fp_s5   <= fp_s4;
			widx_s5 <= widx_s4;
			wval_s5 <= wval_s4;

			// corner samples arrive from the grid copies with this stage
			ft_s6 <= ft_s5;
			fp_s6 <= fp_s5;

			m00_s7 <= (ONE - ft_s6) * g00;
			m01_s7 <= ft_s6 * g01;
			m10_s7 <= (ONE - ft_s6) * g10;
			m11_s7 <= ft_s6 * g11;
			fp_s7  <= fp_s6;

			a0_s8 <= sum0[FRAC_BITS +: VW];
			a1_s8 <= sum1[FRAC_BITS +: VW];
			fp_s8 <= fp_s7;

			n0_s9 <= (ONE - fp_s8) * a0_s8;
			n1_s9 <= fp_s8 * a1_s8;

			area_q <= sum_out[FRAC_BITS +: VW];
		end
	end

	// write items never give a result
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s9 && !q_s9 |=> !out_valid_q)
		else $error("write item produced a result");

	// blend fractions stay within one
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && q_s4 |-> ft_s4 <= ONE && fp_s4 <= ONE)
		else $error("blend fraction above one");

	// all four corners of a query lie inside the grid store
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && q_s5 |-> 32'(r0_s5) + 32'(nt) + 32'd1 < 32'(GRID_DEPTH))
		else $error("corner address beyond grid store");

	// a query reaching the output stage is shown as a result
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s9 && q_s9 |=> out_valid_q)
		else $error("query result lost");

endmodule
